FILE: design/cqp_pkg.sv
// ----------------------------------------------------------------------------
// cqp_pkg
// shared types and constants for the chebyshev quadrature point generator
// ----------------------------------------------------------------------------
package cqp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 16;
  localparam int OUT_W      = 17;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b1;

  // rule codes
  localparam logic [1:0] RULE_TABLE  = 2'd0;
  localparam logic [1:0] RULE_FIRST  = 2'd1;
  localparam logic [1:0] RULE_SECOND = 2'd2;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] DEC_ONE  = 64'd10000000000;
  localparam logic [63:0] HALF_DEC = DEC_ONE / 64'd2;

  // series arithmetic widths
  localparam int TRIG_ITERS = 8;
  localparam int X2_W   = 32;
  localparam int TERM_W = 32;
  localparam int V_W    = 34;
  localparam int SUM_W  = 36;
  localparam int RCP_W  = 34;
  localparam int D_W    = 9;

  // series divisors and their reciprocals scaled by 2^V_W
  localparam logic [D_W-1:0] D_COS [TRIG_ITERS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240
  };
  localparam logic [D_W-1:0] D_SIN [TRIG_ITERS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
  };
  localparam logic [RCP_W-1:0] RCP_COS [TRIG_ITERS] = '{
    34'((64'd1 << 34) / 64'd2),   34'((64'd1 << 34) / 64'd12),
    34'((64'd1 << 34) / 64'd30),  34'((64'd1 << 34) / 64'd56),
    34'((64'd1 << 34) / 64'd90),  34'((64'd1 << 34) / 64'd132),
    34'((64'd1 << 34) / 64'd182), 34'((64'd1 << 34) / 64'd240)
  };
  localparam logic [RCP_W-1:0] RCP_SIN [TRIG_ITERS] = '{
    34'((64'd1 << 34) / 64'd6),   34'((64'd1 << 34) / 64'd20),
    34'((64'd1 << 34) / 64'd42),  34'((64'd1 << 34) / 64'd72),
    34'((64'd1 << 34) / 64'd110), 34'((64'd1 << 34) / 64'd156),
    34'((64'd1 << 34) / 64'd210), 34'((64'd1 << 34) / 64'd272)
  };

  // fixed node magnitude (units of 1e-10) to q30
  function automatic logic [30:0] node_q30(input logic [63:0] mag);
    return 31'((mag * ONE_Q30 + HALF_DEC) / DEC_ONE);
  endfunction

  // distinct node magnitudes, rows 2..7 and 9 in order, outer node first
  localparam logic [30:0] NODE_Q30 [16] = '{
    node_q30(64'd5773502692), node_q30(64'd7071067812),
    node_q30(64'd7946544723), node_q30(64'd1875924741),
    node_q30(64'd8324974870), node_q30(64'd3745414096),
    node_q30(64'd8662468181), node_q30(64'd4225186538),
    node_q30(64'd2666354015), node_q30(64'd8838617008),
    node_q30(64'd5296567753), node_q30(64'd3239118105),
    node_q30(64'd9115893077), node_q30(64'd6010186554),
    node_q30(64'd5287617831), node_q30(64'd1679061842)
  };

  typedef struct packed {
    logic        neg;
    logic [30:0] c;
  } node_t;

  // fixed table node for count n, index i; zero for rows without a table
  function automatic node_t node_lookup(input logic [4:0] n, input logic [3:0] i);
    logic [3:0] base;
    logic       row_ok;
    logic [3:0] half;
    logic [3:0] j;
    node_t      r;
    row_ok = 1'b1;
    base   = 4'd0;
    unique case (n)
      5'd2:    base = 4'd0;
      5'd3:    base = 4'd1;
      5'd4:    base = 4'd2;
      5'd5:    base = 4'd4;
      5'd6:    base = 4'd6;
      5'd7:    base = 4'd9;
      5'd9:    base = 4'd12;
      default: row_ok = 1'b0;
    endcase
    half = n[4:1];
    r.neg = 1'b0;
    r.c   = '0;
    if (row_ok) begin
      if (i < half) begin
        j     = i;
        r.neg = 1'b1;
        r.c   = NODE_Q30[4'(base + j)];
      end else if (n[0] && i == half) begin
        r.c = '0;
      end else begin
        j   = 4'(n[3:0] - 4'd1 - i);
        r.c = NODE_Q30[4'(base + j)];
      end
    end
    return r;
  endfunction

  // item attributes carried down the pipeline
  typedef struct packed {
    logic [1:0]  rule;
    logic [4:0]  n;
    logic        err;
    logic        neg;
    node_t       node;
  } side_t;

  typedef struct packed {
    logic             err;
    logic [OUT_W-1:0] loc;
  } tail_t;

  typedef struct packed {
    logic [OUT_W-1:0] location;
    logic [OUT_W-1:0] weight;
    logic             index_error;
  } res_t;

endpackage

FILE: design/chebyshev_quadrature_points.sv
// ----------------------------------------------------------------------------
// chebyshev_quadrature_points
// location and weight of one quadrature point per transfer, 16 fraction bits
// ----------------------------------------------------------------------------
// Each input transfer names a point index; one result transfer returns that
// point's location on [0,1] and its weight, or the error flag with zeros when
// the index is not below the point count. The block is a 47-stage pipeline
// that takes one index every cycle while the output buffer has room: a 9-stage
// radix-16 divider folds the angle, 24 stages run the 8-term cosine and sine
// series (multiply, reciprocal multiply, correct), and a 5-stage divider forms
// the weight. A two-entry output buffer decouples the result channel, so an
// index is taken while a finished result waits. Configuration is written
// through cfg_we/cfg_index/cfg_wdata; the user must write it only while no
// item is in flight, as the block itself does not enforce this.
module chebyshev_quadrature_points (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cqp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [4:0]                           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [3:0]                           in_point_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cqp_pkg::OUT_W-1:0]            out_location,
  output logic [cqp_pkg::OUT_W-1:0]            out_weight,
  output logic                                 out_index_error
);

  // stage map
  localparam int ST_CAP   = 0;
  localparam int ST_NUM   = 1;
  localparam int D1_STEPS = 9;
  localparam int ST_D1    = 2;
  localparam int ST_SQ    = ST_D1 + D1_STEPS;
  localparam int ST_X2    = ST_SQ + 1;
  localparam int ST_CLAMP = ST_X2 + 3 * cqp_pkg::TRIG_ITERS + 1;
  localparam int ST_LOC   = ST_CLAMP + 1;
  localparam int ST_S2    = ST_LOC + 1;
  localparam int ST_PS2   = ST_S2 + 1;
  localparam int ST_PREP  = ST_PS2 + 1;
  localparam int D2_STEPS = 5;
  localparam int ST_D2    = ST_PREP + 1;
  localparam int NST      = ST_D2 + D2_STEPS;
  localparam int TAIL_N   = NST - ST_LOC;

  localparam int D1_W = 4 * D1_STEPS;
  localparam int D2_W = 4 * D2_STEPS;
  localparam int F    = cqp_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0] rule_type_r;
  logic [4:0] point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_type_r   <= cqp_pkg::RULE_TABLE;
      point_count_r <= 5'd2;
    end else if (cfg_we) begin
      if (cfg_index == cqp_pkg::CFG_RULE_TYPE) begin
        rule_type_r <= cfg_wdata[1:0];
      end
      if (cfg_index == cqp_pkg::CFG_POINT_COUNT) begin
        point_count_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: all stages move together while the output buffer has
  // room; the buffer fill is registered so nothing combinational crosses
  // --------------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] v_r;
  logic [1:0]     cnt_r;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: capture, saturate count, fold the angle numerator
  // --------------------------------------------------------------------------
  cqp_pkg::side_t side_nxt;
  cqp_pkg::side_t side_r [ST_PREP];
  logic [4:0]     n_sat;
  logic [1:0]     rule_eff;
  logic [5:0]     ang_a, ang_b, ap_nxt;
  logic [5:0]     ap0_r, b0_r;

  always_comb begin
    n_sat    = (point_count_r > 5'(cqp_pkg::MAX_POINTS)) ? 5'(cqp_pkg::MAX_POINTS)
                                                         : point_count_r;
    rule_eff = (rule_type_r > cqp_pkg::RULE_SECOND) ? cqp_pkg::RULE_TABLE : rule_type_r;
    // second kind: angle (i+1)pi/(n+1); otherwise (2i+1)pi/2n
    if (rule_eff == cqp_pkg::RULE_SECOND) begin
      ang_a = 6'(in_point_index) + 6'd1;
      ang_b = 6'(n_sat) + 6'd1;
    end else begin
      ang_a = {1'b0, in_point_index, 1'b1};
      ang_b = {n_sat, 1'b0};
    end
    side_nxt.rule = rule_eff;
    side_nxt.n    = n_sat;
    side_nxt.err  = ({1'b0, in_point_index} >= n_sat);
    side_nxt.neg  = ({ang_a, 1'b0} > {1'b0, ang_b});
    side_nxt.node = cqp_pkg::node_lookup(n_sat, in_point_index);
    ap_nxt        = side_nxt.neg ? 6'(ang_b - ang_a) : ang_a;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[ST_CAP] <= side_nxt;
      ap0_r          <= ap_nxt;
      b0_r           <= ang_b;
      for (int k = 1; k < ST_PREP; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: dividend pi*a' + b/2
  // --------------------------------------------------------------------------
  logic [D1_W-1:0] num_r;
  logic [5:0]      numb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= D1_W'(cqp_pkg::PI_Q30) * D1_W'(ap0_r) + D1_W'(b0_r >> 1);
      numb_r <= b0_r;
    end
  end

  // --------------------------------------------------------------------------
  // angle divider: four quotient bits per stage, msb first
  // --------------------------------------------------------------------------
  logic [D1_W-1:0] d1_num_r [D1_STEPS];
  logic [D1_W-1:0] d1_q_r   [D1_STEPS];
  logic [5:0]      d1_rem_r [D1_STEPS];
  logic [5:0]      d1_b_r   [D1_STEPS];

  for (genvar j = 0; j < D1_STEPS; j++) begin : g_d1
    logic [D1_W-1:0] num_in, q_in, num_o, q_o;
    logic [5:0]      rem_in, b_in, rem_o;

    if (j == 0) begin : g_head
      assign num_in = num_r;
      assign q_in   = '0;
      assign rem_in = '0;
      assign b_in   = numb_r;
    end else begin : g_body
      assign num_in = d1_num_r[j-1];
      assign q_in   = d1_q_r[j-1];
      assign rem_in = d1_rem_r[j-1];
      assign b_in   = d1_b_r[j-1];
    end

    always_comb begin
      logic [6:0] t;
      num_o = num_in;
      q_o   = q_in;
      rem_o = rem_in;
      for (int s = 0; s < 4; s++) begin
        t     = {rem_o, num_o[D1_W-1]};
        num_o = num_o << 1;
        if (t >= {1'b0, b_in}) begin
          t   = t - {1'b0, b_in};
          q_o = {q_o[D1_W-2:0], 1'b1};
        end else begin
          q_o = {q_o[D1_W-2:0], 1'b0};
        end
        rem_o = t[5:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1_num_r[j] <= num_o;
        d1_q_r[j]   <= q_o;
        d1_rem_r[j] <= rem_o;
        d1_b_r[j]   <= b_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // phi squared, then x2 and series seeds
  // --------------------------------------------------------------------------
  logic [30:0] phi_r;
  logic [61:0] sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      phi_r <= d1_q_r[D1_STEPS-1][30:0];
      sq_r  <= d1_q_r[D1_STEPS-1][30:0] * d1_q_r[D1_STEPS-1][30:0];
    end
  end

  // index 0 holds the seeds, index it+1 the state after series term it
  logic [cqp_pkg::TERM_W-1:0]       c_ct_r [cqp_pkg::TRIG_ITERS+1];
  logic [cqp_pkg::TERM_W-1:0]       c_st_r [cqp_pkg::TRIG_ITERS+1];
  logic [cqp_pkg::X2_W-1:0]         c_x2_r [cqp_pkg::TRIG_ITERS+1];
  logic signed [cqp_pkg::SUM_W-1:0] c_cs_r [cqp_pkg::TRIG_ITERS+1];
  logic signed [cqp_pkg::SUM_W-1:0] c_ss_r [cqp_pkg::TRIG_ITERS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x2_r[0] <= cqp_pkg::X2_W'((64'(sq_r) + 64'd536870912) >> 30);
      c_ct_r[0] <= cqp_pkg::TERM_W'(cqp_pkg::ONE_Q30);
      c_st_r[0] <= cqp_pkg::TERM_W'(phi_r);
      c_cs_r[0] <= cqp_pkg::SUM_W'(cqp_pkg::ONE_Q30);
      c_ss_r[0] <= cqp_pkg::SUM_W'(phi_r);
    end
  end

  // --------------------------------------------------------------------------
  // cosine and sine series, three stages per term:
  // multiply by x2, round and multiply by the divisor reciprocal, correct
  // the quotient and accumulate with alternating sign
  // --------------------------------------------------------------------------
  logic [63:0]                      a_pc_r [cqp_pkg::TRIG_ITERS];
  logic [63:0]                      a_ps_r [cqp_pkg::TRIG_ITERS];
  logic [cqp_pkg::X2_W-1:0]         a_x2_r [cqp_pkg::TRIG_ITERS];
  logic signed [cqp_pkg::SUM_W-1:0] a_cs_r [cqp_pkg::TRIG_ITERS];
  logic signed [cqp_pkg::SUM_W-1:0] a_ss_r [cqp_pkg::TRIG_ITERS];

  logic [cqp_pkg::V_W-1:0]          b_vc_r [cqp_pkg::TRIG_ITERS];
  logic [cqp_pkg::V_W-1:0]          b_vs_r [cqp_pkg::TRIG_ITERS];
  logic [2*cqp_pkg::V_W-1:0]        b_mc_r [cqp_pkg::TRIG_ITERS];
  logic [2*cqp_pkg::V_W-1:0]        b_ms_r [cqp_pkg::TRIG_ITERS];
  logic [cqp_pkg::X2_W-1:0]         b_x2_r [cqp_pkg::TRIG_ITERS];
  logic signed [cqp_pkg::SUM_W-1:0] b_cs_r [cqp_pkg::TRIG_ITERS];
  logic signed [cqp_pkg::SUM_W-1:0] b_ss_r [cqp_pkg::TRIG_ITERS];

  for (genvar it = 0; it < cqp_pkg::TRIG_ITERS; it++) begin : g_trig
    logic [cqp_pkg::V_W-1:0]          vc, vs, qc0, qs0, rc, rs, qc, qs;
    logic signed [cqp_pkg::SUM_W-1:0] cs_o, ss_o;

    always_ff @(posedge clk) begin
      if (adv) begin
        a_pc_r[it] <= c_ct_r[it] * c_x2_r[it];
        a_ps_r[it] <= c_st_r[it] * c_x2_r[it];
        a_x2_r[it] <= c_x2_r[it];
        a_cs_r[it] <= c_cs_r[it];
        a_ss_r[it] <= c_ss_r[it];
      end
    end

    assign vc = cqp_pkg::V_W'((a_pc_r[it] + 64'd536870912) >> 30);
    assign vs = cqp_pkg::V_W'((a_ps_r[it] + 64'd536870912) >> 30);

    always_ff @(posedge clk) begin
      if (adv) begin
        b_vc_r[it] <= vc;
        b_vs_r[it] <= vs;
        b_mc_r[it] <= vc * cqp_pkg::RCP_COS[it];
        b_ms_r[it] <= vs * cqp_pkg::RCP_SIN[it];
        b_x2_r[it] <= a_x2_r[it];
        b_cs_r[it] <= a_cs_r[it];
        b_ss_r[it] <= a_ss_r[it];
      end
    end

    // reciprocal estimate is exact or one low
    always_comb begin
      qc0 = b_mc_r[it][2*cqp_pkg::V_W-1:cqp_pkg::V_W];
      qs0 = b_ms_r[it][2*cqp_pkg::V_W-1:cqp_pkg::V_W];
      rc  = b_vc_r[it] - cqp_pkg::V_W'(qc0 * cqp_pkg::D_COS[it]);
      rs  = b_vs_r[it] - cqp_pkg::V_W'(qs0 * cqp_pkg::D_SIN[it]);
      qc  = (rc >= cqp_pkg::V_W'(cqp_pkg::D_COS[it])) ? qc0 + 1'b1 : qc0;
      qs  = (rs >= cqp_pkg::V_W'(cqp_pkg::D_SIN[it])) ? qs0 + 1'b1 : qs0;
      if ((it % 2) == 0) begin
        cs_o = b_cs_r[it] - $signed(cqp_pkg::SUM_W'(qc));
        ss_o = b_ss_r[it] - $signed(cqp_pkg::SUM_W'(qs));
      end else begin
        cs_o = b_cs_r[it] + $signed(cqp_pkg::SUM_W'(qc));
        ss_o = b_ss_r[it] + $signed(cqp_pkg::SUM_W'(qs));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c_ct_r[it+1] <= cqp_pkg::TERM_W'(qc);
        c_st_r[it+1] <= cqp_pkg::TERM_W'(qs);
        c_x2_r[it+1] <= b_x2_r[it];
        c_cs_r[it+1] <= cs_o;
        c_ss_r[it+1] <= ss_o;
      end
    end
  end

  // --------------------------------------------------------------------------
  // clamp both sums to [0, 1]
  // --------------------------------------------------------------------------
  localparam logic signed [cqp_pkg::SUM_W-1:0] ONE_S = cqp_pkg::SUM_W'(cqp_pkg::ONE_Q30);

  logic [30:0] clc_r, cls_r;

  function automatic logic [30:0] clamp_q30(input logic signed [cqp_pkg::SUM_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > ONE_S) begin
      return 31'(cqp_pkg::ONE_Q30);
    end else begin
      return v[30:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      clc_r <= clamp_q30(c_cs_r[cqp_pkg::TRIG_ITERS]);
      cls_r <= clamp_q30(c_ss_r[cqp_pkg::TRIG_ITERS]);
    end
  end

  // --------------------------------------------------------------------------
  // location, and sine squared for the second-kind weight
  // --------------------------------------------------------------------------
  cqp_pkg::tail_t tail_r [TAIL_N];
  cqp_pkg::tail_t tail_nxt;
  logic [61:0]    ss_r;
  logic [30:0]    c_sel;
  logic           neg_sel;
  logic [31:0]    q31;

  always_comb begin
    if (side_r[ST_CLAMP].rule == cqp_pkg::RULE_TABLE) begin
      c_sel   = side_r[ST_CLAMP].node.c;
      neg_sel = side_r[ST_CLAMP].node.neg;
    end else begin
      c_sel   = clc_r;
      neg_sel = side_r[ST_CLAMP].neg;
    end
    q31 = neg_sel ? 32'(cqp_pkg::ONE_Q30) - 32'(c_sel)
                  : 32'(cqp_pkg::ONE_Q30) + 32'(c_sel);
    tail_nxt.err = side_r[ST_CLAMP].err;
    tail_nxt.loc = side_r[ST_CLAMP].err ? '0
      : cqp_pkg::OUT_W'((33'(q31) + (33'd1 << (30 - F))) >> (31 - F));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_r[0] <= tail_nxt;
      ss_r      <= cls_r * cls_r;
      for (int k = 1; k < TAIL_N; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // weight numerator
  // --------------------------------------------------------------------------
  logic [30:0]     s2_r;
  logic [62:0]     ps2_r;
  logic [D2_W-1:0] wnum_nxt, wnum_r;
  logic [5:0]      wb_nxt, wb_r;
  logic [4:0]      wn;
  logic [5:0]      wm;
  logic [63:0]     t1, t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r  <= 31'((64'(ss_r) + 64'd536870912) >> 30);
      ps2_r <= cqp_pkg::PI_Q30 * s2_r;
    end
  end

  always_comb begin
    wn = side_r[ST_PREP-1].n;
    wm = 6'(wn) + 6'd1;
    t1 = 64'(cqp_pkg::PI_Q30) + (64'(wn) << (30 - F));
    t2 = 64'(ps2_r) + (64'(wm) << (60 - F));
    if (side_r[ST_PREP-1].err) begin
      wnum_nxt = '0;
      wb_nxt   = 6'd1;
    end else begin
      unique case (side_r[ST_PREP-1].rule)
        cqp_pkg::RULE_FIRST: begin
          wnum_nxt = D2_W'(t1 >> (31 - F));
          wb_nxt   = 6'(wn);
        end
        cqp_pkg::RULE_SECOND: begin
          wnum_nxt = D2_W'(t2 >> (61 - F));
          wb_nxt   = wm;
        end
        default: begin
          wnum_nxt = D2_W'(1 << F) + D2_W'(wn >> 1);
          wb_nxt   = 6'(wn);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wnum_r <= wnum_nxt;
      wb_r   <= wb_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // weight divider, four quotient bits per stage
  // --------------------------------------------------------------------------
  logic [D2_W-1:0] d2_num_r [D2_STEPS];
  logic [D2_W-1:0] d2_q_r   [D2_STEPS];
  logic [5:0]      d2_rem_r [D2_STEPS];
  logic [5:0]      d2_b_r   [D2_STEPS];

  for (genvar j = 0; j < D2_STEPS; j++) begin : g_d2
    logic [D2_W-1:0] num_in, q_in, num_o, q_o;
    logic [5:0]      rem_in, b_in, rem_o;

    if (j == 0) begin : g_head
      assign num_in = wnum_r;
      assign q_in   = '0;
      assign rem_in = '0;
      assign b_in   = wb_r;
    end else begin : g_body
      assign num_in = d2_num_r[j-1];
      assign q_in   = d2_q_r[j-1];
      assign rem_in = d2_rem_r[j-1];
      assign b_in   = d2_b_r[j-1];
    end

    always_comb begin
      logic [6:0] t;
      num_o = num_in;
      q_o   = q_in;
      rem_o = rem_in;
      for (int s = 0; s < 4; s++) begin
        t     = {rem_o, num_o[D2_W-1]};
        num_o = num_o << 1;
        if (t >= {1'b0, b_in}) begin
          t   = t - {1'b0, b_in};
          q_o = {q_o[D2_W-2:0], 1'b1};
        end else begin
          q_o = {q_o[D2_W-2:0], 1'b0};
        end
        rem_o = t[5:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d2_num_r[j] <= num_o;
        d2_q_r[j]   <= q_o;
        d2_rem_r[j] <= rem_o;
        d2_b_r[j]   <= b_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // two-entry output buffer
  // --------------------------------------------------------------------------
  cqp_pkg::res_t ob_r [2];
  cqp_pkg::res_t res_nxt;
  logic          wp_r, rp_r;
  logic          push, pop;
  logic [1:0]    cnt_nxt;

  assign push = adv & v_r[NST-1];
  assign pop  = out_valid & out_ready;

  always_comb begin
    res_nxt.location    = tail_r[TAIL_N-1].loc;
    res_nxt.weight      = d2_q_r[D2_STEPS-1][cqp_pkg::OUT_W-1:0];
    res_nxt.index_error = tail_r[TAIL_N-1].err;
    cnt_nxt             = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_r[wp_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_location    = ob_r[rp_r].location;
  assign out_weight      = ob_r[rp_r].weight;
  assign out_index_error = ob_r[rp_r].index_error;

endmodule
